FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/deqc_pkg.sv
package deqc_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_BACK  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    // Item held between the pointer update and the result register.
    typedef struct packed {
        logic                     pop;
        logic                     empty;
        logic                     ovf;
        logic signed [WORD_W-1:0] value;
    } stage_t;

endpackage

FILE: rtl/core/deqc_ram.sv
module deqc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/double_ended_queue_checker.sv
// Bounded double-ended queue of 32-bit signed words with pop checking. Each input word is
// one command (push front, pop front, push back, pop back); every command gives exactly one
// result word. A pop returns the front or back word, or -1 with was_empty set when the queue
// is empty, and compares it with the command's value; all_matched stays low after the first
// mismatch until reset. A push into a full queue is dropped and flagged as overflow. The words
// live in a 64-entry single-port-write, single-port-read RAM with a registered read port:
// pointers and occupancy are updated and the RAM read register is loaded as a command is
// accepted, and the result is registered from the staged command and the RAM read register
// once the output register is free, so a stalled output holds the staged command back; one
// command can be accepted every cycle while results are taken.
module double_ended_queue_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_popped_value,
    output logic               m_was_empty,
    output logic               m_overflow,
    output logic               m_matched,
    output logic               m_all_matched
);

    localparam logic [deqc_pkg::ADDR_W-1:0] LAST_SLOT =
        deqc_pkg::ADDR_W'(deqc_pkg::CAPACITY - 1);

    logic [deqc_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [deqc_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [deqc_pkg::OCC_W-1:0]  occ_reg, occ_next;
    logic                        all_ok_reg, all_ok_next;
    logic                        st_valid_reg, st_valid_next;
    logic                        m_valid_reg, m_valid_next;
    deqc_pkg::stage_t            st_reg;

    logic signed [31:0] popped_reg;
    logic               empty_reg, ovf_reg, match_reg;

    logic [deqc_pkg::ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [deqc_pkg::ADDR_W-1:0] waddr, raddr;
    logic [deqc_pkg::WORD_W-1:0] rdata;
    logic                        we, re;
    logic                        accept, out_free, st_go, full, empty;
    logic                        is_pop;
    logic signed [31:0]          popped;
    logic                        match;
    deqc_pkg::mode_t             mode;

    assign mode   = deqc_pkg::mode_t'(s_mode);
    assign is_pop = (mode == deqc_pkg::MODE_POP_FRONT) || (mode == deqc_pkg::MODE_POP_BACK);
    assign full   = (occ_reg == deqc_pkg::OCC_W'(deqc_pkg::CAPACITY));
    assign empty  = (occ_reg == '0);

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_SLOT : tail_reg - 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign st_go    = st_valid_reg && out_free;
    assign s_ready  = !st_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        we        = 1'b0;
        re        = 1'b0;
        waddr     = tail_reg;
        raddr     = head_reg;
        if (accept) begin
            unique case (mode)
                deqc_pkg::MODE_PUSH_FRONT: begin
                    if (!full) begin
                        head_next = head_dec;
                        we        = 1'b1;
                        waddr     = head_dec;
                        occ_next  = occ_reg + 1'b1;
                    end
                end
                deqc_pkg::MODE_PUSH_BACK: begin
                    if (!full) begin
                        tail_next = tail_inc;
                        we        = 1'b1;
                        waddr     = tail_reg;
                        occ_next  = occ_reg + 1'b1;
                    end
                end
                deqc_pkg::MODE_POP_FRONT: begin
                    if (!empty) begin
                        head_next = head_inc;
                        re        = 1'b1;
                        raddr     = head_reg;
                        occ_next  = occ_reg - 1'b1;
                    end
                end
                deqc_pkg::MODE_POP_BACK: begin
                    if (!empty) begin
                        tail_next = tail_dec;
                        re        = 1'b1;
                        raddr     = tail_dec;
                        occ_next  = occ_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // The RAM word is only consulted for a pop that found data; its read register holds
    // while the staged word waits for the output.
    always_comb begin
        if (!st_reg.pop) begin
            popped = '0;
        end else if (st_reg.empty) begin
            popped = deqc_pkg::EMPTY_WORD;
        end else begin
            popped = $signed(rdata);
        end
        match = !st_reg.pop || (popped == st_reg.value);
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (st_go) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        all_ok_next  = all_ok_reg;
        if (st_go) begin
            m_valid_next = 1'b1;
            all_ok_next  = all_ok_reg && match;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            all_ok_reg   <= 1'b1;
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            all_ok_reg   <= all_ok_next;
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg.pop   <= is_pop;
            st_reg.empty <= is_pop && empty;
            st_reg.ovf   <= !is_pop && full;
            st_reg.value <= s_value;
        end
        if (st_go) begin
            popped_reg <= popped;
            empty_reg  <= st_reg.empty;
            ovf_reg    <= st_reg.ovf;
            match_reg  <= match;
        end
    end

    deqc_ram #(
        .DEPTH(deqc_pkg::CAPACITY),
        .WIDTH(deqc_pkg::WORD_W)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(s_value),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_popped_value = popped_reg;
    assign m_was_empty    = empty_reg;
    assign m_overflow     = ovf_reg;
    assign m_matched      = match_reg;
    assign m_all_matched  = all_ok_reg;

endmodule

FILE: rtl/core/deqc_checker.sv
`include "assert_macros.svh"

module deqc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_mode,
    input logic signed [31:0] s_value,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_popped_value,
    input logic               m_was_empty,
    input logic               m_overflow,
    input logic               m_matched,
    input logic               m_all_matched
);

    logic in_word;

    assign in_word = s_valid && s_ready && (s_mode == s_mode) && (s_value == s_value);

    // A dropped push reports no popped word and counts as matched.
    `ASSERT_SAME(a_ovf_push, aclk, aresetn, m_valid && m_overflow, !m_was_empty && m_matched && m_popped_value == 0)
    // A pop from an empty queue reports the empty marker and never an overflow.
    `ASSERT_SAME(a_empty_pop, aclk, aresetn, m_valid && m_was_empty, m_popped_value == -32'sd1 && !m_overflow)
    // A mismatch shows up in the sticky flag of the same word.
    `ASSERT_SAME(a_sticky, aclk, aresetn, m_valid && !m_matched, !m_all_matched)
    // A stalled result word holds its payload.
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready && !in_word, m_valid && $stable(m_popped_value))

endmodule

bind double_ended_queue_checker deqc_checker u_deqc_checker (.*);
